[rtl/bib_pkg.sv]
// bib_pkg: shared widths, opcodes, status codes and beat structs
// for the bucket index builder; no dependencies
package bib_pkg;

    // sizes of the index
    localparam int BUCKET_W    = 12;
    localparam int NUM_BUCKETS = 1 << BUCKET_W;
    localparam int SLOT_W      = 16;
    localparam int INDEX_DEPTH = 1 << SLOT_W;
    localparam int CNT_W       = SLOT_W + 1;
    localparam int POS_W       = 32;

    // stream widths
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int IN_FIELD_W  = BUCKET_W + POS_W + SLOT_W;
    localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 3 * CNT_W + POS_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // opcodes
    localparam logic [OP_W-1:0] OP_COUNT = 3'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 3'd1;
    localparam logic [OP_W-1:0] OP_PLACE = 3'd2;
    localparam logic [OP_W-1:0] OP_RANGE = 3'd3;
    localparam logic [OP_W-1:0] OP_SLOT  = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PHASE = 2'd2;

    // one input beat
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [BUCKET_W-1:0] key;
        logic [POS_W-1:0]    pos;
        logic [SLOT_W-1:0]   slot;
    } cmd_t;

    // one result beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    range_start;
        logic [CNT_W-1:0]    range_end;
        logic [CNT_W-1:0]    total_entries;
        logic [POS_W-1:0]    slot_position;
    } res_t;

endpackage

[rtl/bucket_index_builder.sv]
// bucket_index_builder: top level, stream unpacking and output register
// depends on bib_pkg and bib_ctrl
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata: key, position, slot; s_tuser: opcode
//  m_*      out  m_tvalid/m_tready  m_tdata: start, end, total, position; m_tuser: status
//
// one beat at a time; build offsets walks every bucket, reading and then writing each
// over the tally memory, whose read port is registered
// after reset the tally memory is cleared with s_tready low
// a held result sits in the output register; the next beat is taken meanwhile
module bucket_index_builder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bib_pkg::IN_TDATA_W-1:0]  s_tdata,   // bucket_key, ref_position, slot_number
    input  logic [bib_pkg::OP_W-1:0]        s_tuser,   // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bib_pkg::OUT_TDATA_W-1:0] m_tdata,   // range_start, range_end, total_entries,
                                                       // slot_position
    output logic [bib_pkg::STATUS_W-1:0]    m_tuser    // status
);
    import bib_pkg::*;

    cmd_t                   cmd;
    res_t                   res;
    logic                   res_valid;
    logic                   res_take;
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0]    m_tuser_reg;

    // unpack the input beat
    assign cmd.op   = s_tuser;
    assign cmd.key  = s_tdata[BUCKET_W-1:0];
    assign cmd.pos  = s_tdata[BUCKET_W+POS_W-1:BUCKET_W];
    assign cmd.slot = s_tdata[IN_FIELD_W-1:BUCKET_W+POS_W];

    bib_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // output register
    assign res_take = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid && res_take)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            m_tdata_reg <= {{OUT_PAD_W{1'b0}}, res.slot_position, res.total_entries,
                            res.range_end, res.range_start};
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[rtl/bib_ram.sv]
// bib_ram: simple dual-port ram, one write and one registered read per cycle
// no dependencies
module bib_ram #(
    parameter int AW = 12,
    parameter int DW = 17
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem_reg [(1 << AW)];
    logic [DW-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bib_ctrl.sv]
// bib_ctrl: sequencer with one shared adder over the tally, cursor and
// position memories; depends on bib_pkg and bib_ram
module bib_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  bib_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_take,
    output bib_pkg::res_t res
);
    import bib_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_DISPATCH = 11'b000_0000_0100,
        S_CNT_WR   = 11'b000_0000_1000,
        S_BLD_RD   = 11'b000_0001_0000,
        S_BLD_WR   = 11'b000_0010_0000,
        S_PLC_CHK  = 11'b000_0100_0000,
        S_RNG_RD2  = 11'b000_1000_0000,
        S_RNG_END  = 11'b001_0000_0000,
        S_SLOT_END = 11'b010_0000_0000,
        S_RESP     = 11'b100_0000_0000
    } state_t;

    localparam logic PH_COUNT = 1'b0;
    localparam logic PH_PLACE = 1'b1;

    localparam logic [BUCKET_W-1:0] KEY_LAST = BUCKET_W'(NUM_BUCKETS - 1);

    state_t              state_reg, state_next;
    logic                phase_reg, phase_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [BUCKET_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]    run_reg, run_next;
    cmd_t                cmd_reg, cmd_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CNT_W-1:0]    rs_reg, rs_next;
    logic [CNT_W-1:0]    re_reg, re_next;
    logic [POS_W-1:0]    sp_reg, sp_next;

    // shared adder
    logic [CNT_W-1:0]    add_a, add_b, sum;

    logic [BUCKET_W-1:0] key_inc;
    logic                key_last;
    logic [CNT_W-1:0]    lim;

    // memory ports
    logic                bt_we;
    logic [BUCKET_W-1:0] bt_waddr, bt_raddr;
    logic [CNT_W-1:0]    bt_wdata, bt_rdata;
    logic                fc_we;
    logic [BUCKET_W-1:0] fc_waddr, fc_raddr;
    logic [CNT_W-1:0]    fc_wdata, fc_rdata;
    logic                ps_we;
    logic [SLOT_W-1:0]   ps_waddr, ps_raddr;
    logic [POS_W-1:0]    ps_wdata, ps_rdata;

    // tallies, then start offsets
    bib_ram #(.AW(BUCKET_W), .DW(CNT_W)) u_bucket_ram (
        .clk   (clk),
        .we    (bt_we),
        .waddr (bt_waddr),
        .wdata (bt_wdata),
        .raddr (bt_raddr),
        .rdata (bt_rdata)
    );

    // per-bucket fill cursors
    bib_ram #(.AW(BUCKET_W), .DW(CNT_W)) u_cursor_ram (
        .clk   (clk),
        .we    (fc_we),
        .waddr (fc_waddr),
        .wdata (fc_wdata),
        .raddr (fc_raddr),
        .rdata (fc_rdata)
    );

    // placed positions
    bib_ram #(.AW(SLOT_W), .DW(POS_W)) u_store_ram (
        .clk   (clk),
        .we    (ps_we),
        .waddr (ps_waddr),
        .wdata (ps_wdata),
        .raddr (ps_raddr),
        .rdata (ps_rdata)
    );

    assign sum      = add_a + add_b;
    assign key_inc  = cmd_reg.key + BUCKET_W'(1);
    assign key_last = (cmd_reg.key == KEY_LAST);
    // start of the next bucket, the total for the last one
    assign lim      = key_last ? total_reg : bt_rdata;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        total_next  = total_reg;
        idx_next    = idx_reg;
        run_next    = run_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        rs_next     = rs_reg;
        re_next     = re_reg;
        sp_next     = sp_reg;
        add_a       = '0;
        add_b       = '0;
        bt_we       = 1'b0;
        bt_waddr    = cmd_reg.key;
        bt_wdata    = '0;
        bt_raddr    = cmd_reg.key;
        fc_we       = 1'b0;
        fc_waddr    = cmd_reg.key;
        fc_wdata    = sum;
        fc_raddr    = cmd_reg.key;
        ps_we       = 1'b0;
        ps_waddr    = fc_rdata[SLOT_W-1:0];
        ps_wdata    = cmd_reg.pos;
        ps_raddr    = cmd_reg.slot;
        cmd_ready   = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                bt_we    = 1'b1;
                bt_waddr = idx_reg;
                idx_next = idx_reg + BUCKET_W'(1);
                if (idx_reg == KEY_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                status_next = ST_OK;
                rs_next     = '0;
                re_next     = '0;
                sp_next     = '0;
                state_next  = S_RESP;
                case (cmd_reg.op)
                    OP_COUNT:
                    begin
                        if (phase_reg != PH_COUNT)
                        begin
                            status_next = ST_PHASE;
                        end
                        else if (total_reg >= CNT_W'(INDEX_DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            add_a      = total_reg;
                            add_b      = CNT_W'(1);
                            total_next = sum;
                            state_next = S_CNT_WR;
                        end
                    end

                    OP_BUILD:
                    begin
                        if (phase_reg != PH_COUNT)
                        begin
                            status_next = ST_PHASE;
                        end
                        else
                        begin
                            idx_next   = '0;
                            run_next   = '0;
                            state_next = S_BLD_RD;
                        end
                    end

                    OP_PLACE:
                    begin
                        if (phase_reg != PH_PLACE)
                        begin
                            status_next = ST_PHASE;
                        end
                        else
                        begin
                            bt_raddr   = key_inc;
                            state_next = S_PLC_CHK;
                        end
                    end

                    OP_RANGE:
                    begin
                        if (phase_reg != PH_PLACE)
                        begin
                            status_next = ST_PHASE;
                        end
                        else
                        begin
                            state_next = S_RNG_RD2;
                        end
                    end

                    OP_SLOT:
                    begin
                        if (phase_reg != PH_PLACE)
                        begin
                            status_next = ST_PHASE;
                        end
                        else if (CNT_W'(cmd_reg.slot) >= total_reg)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            state_next = S_SLOT_END;
                        end
                    end

                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end

            // tally read-modify-write
            S_CNT_WR:
            begin
                add_a      = bt_rdata;
                add_b      = CNT_W'(1);
                bt_we      = 1'b1;
                bt_wdata   = sum;
                state_next = S_RESP;
            end

            // prefix walk over all buckets
            S_BLD_RD:
            begin
                bt_raddr   = idx_reg;
                state_next = S_BLD_WR;
            end

            S_BLD_WR:
            begin
                add_a    = run_reg;
                add_b    = bt_rdata;
                run_next = sum;
                bt_we    = 1'b1;
                bt_waddr = idx_reg;
                bt_wdata = run_reg;
                fc_we    = 1'b1;
                fc_waddr = idx_reg;
                fc_wdata = run_reg;
                if (idx_reg == KEY_LAST)
                begin
                    total_next = sum;
                    phase_next = PH_PLACE;
                    state_next = S_RESP;
                end
                else
                begin
                    idx_next   = idx_reg + BUCKET_W'(1);
                    state_next = S_BLD_RD;
                end
            end

            // bucket full check, then store and bump cursor
            S_PLC_CHK:
            begin
                if (fc_rdata >= lim)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ps_we = 1'b1;
                    add_a = fc_rdata;
                    add_b = CNT_W'(1);
                    fc_we = 1'b1;
                end
                state_next = S_RESP;
            end

            S_RNG_RD2:
            begin
                rs_next    = bt_rdata;
                bt_raddr   = key_inc;
                state_next = S_RNG_END;
            end

            S_RNG_END:
            begin
                re_next    = lim;
                state_next = S_RESP;
            end

            S_SLOT_END:
            begin
                sp_next    = ps_rdata;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            phase_reg <= PH_COUNT;
            total_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            total_reg <= total_next;
            idx_reg   <= idx_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        run_reg    <= run_next;
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        rs_reg     <= rs_next;
        re_reg     <= re_next;
        sp_reg     <= sp_next;
    end

    assign res.status        = status_reg;
    assign res.range_start   = rs_reg;
    assign res.range_end     = re_reg;
    assign res.total_entries = total_reg;
    assign res.slot_position = sp_reg;

endmodule
